### sv/helical_arc_interpolator_top_defines.svh
// assertion macros for the helical arc interpolator
// no dependencies; taken in by the files that carry assertions
`ifndef HELICAL_ARC_INTERPOLATOR_TOP_DEFINES_SVH
`define HELICAL_ARC_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HAI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define HAI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/hai_pkg.sv
// shared types, constants and the arctangent table of the arc interpolator
// no dependencies
`default_nettype none

package hai_pkg;

    localparam int unsigned VEC_W = 44;
    localparam int unsigned ANG_W = 34;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_req;

    typedef struct packed {
        logic start;
        logic vector;
    } t_cordic_req;

    localparam logic [63:0] INV_GAIN_Q24  = 64'd10188014;
    localparam logic [63:0] TWO_PI_Q16    = 64'd411775;
    localparam logic [63:0] ROUND_HALF    = 64'd536870912;
    localparam logic [7:0]  MIN_TRAVEL_SQ = 8'd110;
    localparam logic [3:0]  TINY_LIMIT    = 4'd11;
    localparam t_vec        NORM_LIMIT    = 44'sd274877906944;
    localparam t_ang        HALF_TURN     = 34'sd2147483648;
    localparam t_ang        QUARTER_TURN  = 34'sd1073741824;
    localparam logic [33:0] FULL_TURN     = 34'd4294967296;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/hai_arith.sv
// shared iterative arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root; one step per cycle. depends on hai_pkg
`default_nettype none

module hai_arith (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire hai_pkg::t_arith_req i_req,
    input  wire logic [63:0]         i_a,
    input  wire logic [63:0]         i_b,
    output logic                     o_done,
    output logic [63:0]              o_res
);

    typedef enum logic {A_IDLE, A_RUN} t_state;

    t_state             r_state;
    hai_pkg::t_arith_op r_op;
    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic [63:0]        r_acc;
    logic [64:0]        r_rem;
    logic [5:0]         r_cnt;
    logic               r_done;
    logic [63:0]        r_res;

    logic [64:0] rem_sh;
    logic        div_bit;
    logic [64:0] sq_sum;
    logic        sq_take;
    logic [63:0] sq_root;

    always_comb begin
        rem_sh  = {r_rem[63:0], r_a[63]};
        div_bit = (rem_sh >= {1'b0, r_b});
        sq_sum  = {1'b0, r_acc} + {1'b0, r_b};
        sq_take = ({1'b0, r_a} >= sq_sum);
        sq_root = sq_take ? ((r_acc >> 1) + r_b) : (r_acc >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_a;
                        r_acc   <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= A_RUN;
                        if (i_req.op == hai_pkg::OP_SQRT) begin
                            r_b <= 64'h4000_0000_0000_0000;
                        end else begin
                            r_b <= i_b;
                        end
                    end
                end
                A_RUN: begin
                    case (r_op)
                        hai_pkg::OP_MUL: begin
                            if (r_b == '0) begin
                                r_res   <= r_acc;
                                r_done  <= 1'b1;
                                r_state <= A_IDLE;
                            end else begin
                                if (r_b[0]) begin
                                    r_acc <= r_acc + r_a;
                                end
                                r_a <= r_a << 1;
                                r_b <= r_b >> 1;
                            end
                        end
                        hai_pkg::OP_DIV: begin
                            r_rem <= div_bit ? (rem_sh - {1'b0, r_b}) : rem_sh;
                            r_a   <= {r_a[62:0], div_bit};
                            r_cnt <= r_cnt + 6'd1;
                            if (r_cnt == 6'd63) begin
                                r_res   <= {r_a[62:0], div_bit};
                                r_done  <= 1'b1;
                                r_state <= A_IDLE;
                            end
                        end
                        hai_pkg::OP_SQRT: begin
                            if (sq_take) begin
                                r_a <= r_a - sq_sum[63:0];
                            end
                            r_acc <= sq_root;
                            r_b   <= r_b >> 2;
                            if (r_b == 64'd1) begin
                                r_res   <= sq_root;
                                r_done  <= 1'b1;
                                r_state <= A_IDLE;
                            end
                        end
                        default: begin
                            r_state <= A_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

### sv/hai_cordic.sv
// iterative cordic, vectoring (angle of a vector) and rotation, one stage
// per cycle. depends on hai_pkg
`default_nettype none

module hai_cordic #(
    parameter int STAGES = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire hai_pkg::t_cordic_req i_req,
    input  wire hai_pkg::t_vec        i_x,
    input  wire hai_pkg::t_vec        i_y,
    input  wire hai_pkg::t_ang        i_z,
    output logic                      o_done,
    output hai_pkg::t_vec             o_x,
    output hai_pkg::t_vec             o_y,
    output hai_pkg::t_ang             o_z
);

    localparam int CW = $clog2(STAGES);

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} t_state;

    t_state        r_state;
    logic          r_vec;
    logic [CW-1:0] r_i;
    hai_pkg::t_vec r_x;
    hai_pkg::t_vec r_y;
    hai_pkg::t_ang r_z;
    logic          r_done;

    hai_pkg::t_vec rot_x, rot_y, xs, ys, n_x, n_y;
    hai_pkg::t_ang rot_z, n_z, atan_v;
    logic          small_vec;
    logic          go_pos;

    // quadrant fold and pre-scale for rotation
    always_comb begin
        rot_x = i_x <<< 6;
        rot_y = i_y <<< 6;
        rot_z = i_z;
        if (i_z > hai_pkg::QUARTER_TURN) begin
            rot_x = -(i_x <<< 6);
            rot_y = -(i_y <<< 6);
            rot_z = i_z - hai_pkg::HALF_TURN;
        end else if (i_z < -hai_pkg::QUARTER_TURN) begin
            rot_x = -(i_x <<< 6);
            rot_y = -(i_y <<< 6);
            rot_z = i_z + hai_pkg::HALF_TURN;
        end
    end

    always_comb begin
        small_vec = (r_x < hai_pkg::NORM_LIMIT) && (r_x > -hai_pkg::NORM_LIMIT) &&
                    (r_y < hai_pkg::NORM_LIMIT) && (r_y > -hai_pkg::NORM_LIMIT);
        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        atan_v = hai_pkg::t_ang'({2'b00, hai_pkg::atan_lut(5'(r_i))});
        go_pos = r_vec ? (r_y > 0) : (r_z < 0);
        if (go_pos) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_vec ? (r_z + atan_v) : (r_z + atan_v);
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_vec <= i_req.vector;
                        r_i   <= '0;
                        if (i_req.vector) begin
                            r_x <= i_x;
                            r_y <= i_y;
                            r_z <= '0;
                            // zero vector has angle zero
                            if (i_x == '0 && i_y == '0) begin
                                r_done <= 1'b1;
                            end else begin
                                r_state <= C_NORM;
                            end
                        end else begin
                            r_x     <= rot_x;
                            r_y     <= rot_y;
                            r_z     <= rot_z;
                            r_state <= C_ITER;
                        end
                    end
                end
                C_NORM: begin
                    if (small_vec) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        if (r_x < 0) begin
                            r_x <= -r_x;
                            r_y <= -r_y;
                            r_z <= hai_pkg::HALF_TURN;
                        end
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    r_i <= r_i + 1'b1;
                    if (r_i == CW'(STAGES - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

`default_nettype wire

### sv/helical_arc_interpolator_top.sv
// top level of the helical arc interpolator: sequencer and arc state
// depends on hai_pkg, hai_cordic, hai_arith and the defines header
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  request   | start, busy           | i_func, i_plane_select, i_clockwise,
//            |                       | i_start_*, i_off_*, i_target_*
//  result    | o_valid (one cycle)   | o_pos_x, o_pos_y, o_pos_z, o_last
//  config    | i_cfg_we              | i_cfg_wdata (segment length, Q0.16 mm)
//
// a step request that is not the last keeps busy high for one cordic rotation
// plus two shift-add multiplies by the inverse gain, all in the shared units;
// the point strobes in the cycle in which busy falls. the final step and any
// step while idle use neither unit and leave busy low. a start request with a
// valid plane runs two cordic vectorings with normalising shifts, up to two
// hypotenuse square roots, the arc-length multiplies and up to three 64-step divides.
// busy is high while a request uses the shared units; results leave as a one-cycle
// strobe and the receiver cannot stall them. synchronous active-low reset
// clears the sequencer and sets the segment length to 0.1 mm.
`default_nettype none
`include "helical_arc_interpolator_top_defines.svh"

module helical_arc_interpolator_top #(
    parameter int MAX_SEGMENTS  = 65536,
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_func,
    input  wire logic [1:0]         i_plane_select,
    input  wire logic               i_clockwise,
    input  wire logic signed [31:0] i_start_x,
    input  wire logic signed [31:0] i_start_y,
    input  wire logic signed [31:0] i_start_z,
    input  wire logic signed [31:0] i_off_x,
    input  wire logic signed [31:0] i_off_y,
    input  wire logic signed [31:0] i_off_z,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_y,
    input  wire logic signed [31:0] i_target_z,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    output logic                    o_valid,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic                    o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_VEC1, S_VEC2, S_HNORM, S_HSQA, S_HSQB, S_HSQRT,
        S_MQ, S_MARC, S_DIVT, S_DIVA, S_DIVN, S_ROT, S_MX, S_MY
    } t_state;

    // function and plane codes of a request
    localparam logic FUNC_START = 1'b0;
    localparam logic [1:0] PLANE_YZ  = 2'd1;
    localparam logic [1:0] PLANE_XZ = 2'd2;
    localparam logic [1:0] PLANE_BAD = 2'd3;

    t_state               r_state;
    logic                 r_active;
    logic [15:0]          r_seg_len;
    logic [1:0]           r_plane;
    logic                 r_cw;
    logic [31:0]          r_centre_a, r_centre_b;
    logic signed [31:0]   r_off_a, r_off_b;
    logic [31:0]          r_norm_pos, r_norm_step;
    logic signed [33:0]   r_angle_step;
    logic [16:0]          r_seg_total, r_seg_index;
    logic [31:0]          r_theta;
    logic [31:0]          r_target [3];
    logic signed [32:0]   r_lin;
    logic [31:0]          r_ang1;
    logic signed [33:0]   r_sweep;
    logic [63:0]          r_h_a, r_h_b, r_h_sum;
    logic [5:0]           r_h_s;
    logic                 r_h_sel;
    hai_pkg::t_vec        r_ya;
    logic [31:0]          r_ra;

    hai_pkg::t_arith_req  r_ari_req;
    logic [63:0]          r_ari_a, r_ari_b;
    hai_pkg::t_cordic_req r_cor_req;
    hai_pkg::t_vec        r_cor_x, r_cor_y;
    hai_pkg::t_ang        r_cor_z;

    logic                 r_valid, r_last;
    logic [31:0]          r_pos [3];

    logic                 ari_done, cor_done;
    logic [63:0]          ari_res;
    hai_pkg::t_vec        cor_x, cor_y;
    hai_pkg::t_ang        cor_z;

    // --------------------------------------------------------------------
    // shared units
    // --------------------------------------------------------------------
    hai_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_ari_req),
        .i_a     (r_ari_a),
        .i_b     (r_ari_b),
        .o_done  (ari_done),
        .o_res   (ari_res)
    );

    hai_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_cor_req),
        .i_x     (r_cor_x),
        .i_y     (r_cor_y),
        .i_z     (r_cor_z),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_z     (cor_z)
    );

    // --------------------------------------------------------------------
    // axis selection of an incoming start request
    // --------------------------------------------------------------------
    logic signed [31:0] sa, sb, sn, oa, ob, ta, tb, tn;
    logic signed [33:0] ca34, cb34, rt0, rt1;
    logic signed [32:0] lin33;

    always_comb begin
        unique case (i_plane_select)
            PLANE_YZ: begin
                sa = i_start_y;  sb = i_start_z;  sn = i_start_x;
                oa = i_off_y;    ob = i_off_z;
                ta = i_target_y; tb = i_target_z; tn = i_target_x;
            end
            PLANE_XZ: begin
                sa = i_start_x;  sb = i_start_z;  sn = i_start_y;
                oa = i_off_x;    ob = i_off_z;
                ta = i_target_x; tb = i_target_z; tn = i_target_y;
            end
            default: begin
                sa = i_start_x;  sb = i_start_y;  sn = i_start_z;
                oa = i_off_x;    ob = i_off_y;
                ta = i_target_x; tb = i_target_y; tn = i_target_z;
            end
        endcase
        ca34  = 34'(sa) + 34'(oa);
        cb34  = 34'(sb) + 34'(ob);
        rt0   = 34'(ta) - ca34;
        rt1   = 34'(tb) - cb34;
        lin33 = 33'(tn) - 33'(sn);
    end

    // --------------------------------------------------------------------
    // helpers on the latched arc
    // --------------------------------------------------------------------
    logic [33:0] sw_abs;
    logic [32:0] lin_abs, off_a_abs, off_b_abs;
    logic [63:0] seg_div, hyp, seg_sat64, arc, lin20, rnd;
    logic [16:0] seg_sat;
    logic        tiny;
    logic [7:0]  tiny_sq;
    logic [17:0] idx;
    logic [31:0] n_theta, n_norm, rb;
    logic [31:0] pos_a, pos_b;

    always_comb begin
        sw_abs    = r_sweep[33] ? 34'(-r_sweep) : 34'(r_sweep);
        lin_abs   = r_lin[32] ? 33'(-r_lin) : 33'(r_lin);
        off_a_abs = r_off_a[31] ? -33'(r_off_a) : 33'(r_off_a);
        off_b_abs = r_off_b[31] ? -33'(r_off_b) : 33'(r_off_b);
        // a zero segment length acts as one
        seg_div   = (r_seg_len == '0) ? 64'd16 : (64'(r_seg_len) << 4);
        hyp       = ari_res << r_h_s;
        seg_sat64 = (ari_res > 64'(MAX_SEGMENTS)) ? 64'(MAX_SEGMENTS) : ari_res;
        seg_sat   = seg_sat64[16:0];
        arc       = ari_res >> 20;
        lin20     = {27'd0, lin_abs, 4'd0};
        tiny_sq   = 8'(arc[3:0]) * 8'(arc[3:0]) + 8'(lin20[3:0]) * 8'(lin20[3:0]);
        tiny      = (arc < 64'(hai_pkg::TINY_LIMIT)) && (lin20 < 64'(hai_pkg::TINY_LIMIT)) &&
                    (tiny_sq < hai_pkg::MIN_TRAVEL_SQ);
        idx       = 18'(r_seg_index) + 18'd1;
        n_theta   = r_theta + r_angle_step[31:0];
        n_norm    = r_norm_pos + r_norm_step;
        rnd       = ari_res + hai_pkg::ROUND_HALF;
        rb        = rnd[61:30];
        pos_a     = r_centre_a + r_ra;
        pos_b     = r_centre_b + rb;
    end

    // --------------------------------------------------------------------
    // sequencer
    // --------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_active        <= 1'b0;
            r_seg_len       <= 16'd6554;
            r_valid         <= 1'b0;
            r_ari_req.start <= 1'b0;
            r_cor_req.start <= 1'b0;
        end else begin
            r_valid         <= 1'b0;
            r_ari_req.start <= 1'b0;
            r_cor_req.start <= 1'b0;
            if (i_cfg_we) begin
                r_seg_len <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_func == FUNC_START) begin
                            // a start always drops the running arc
                            r_active <= 1'b0;
                            if (i_plane_select != PLANE_BAD) begin
                                r_plane     <= i_plane_select;
                                r_cw        <= i_clockwise;
                                r_centre_a  <= ca34[31:0];
                                r_centre_b  <= cb34[31:0];
                                r_off_a     <= oa;
                                r_off_b     <= ob;
                                r_norm_pos  <= sn;
                                r_lin       <= lin33;
                                r_target[0] <= i_target_x;
                                r_target[1] <= i_target_y;
                                r_target[2] <= i_target_z;
                                // angle of centre-to-target first
                                r_cor_x     <= hai_pkg::t_vec'(rt0);
                                r_cor_y     <= hai_pkg::t_vec'(rt1);
                                r_cor_z     <= '0;
                                r_cor_req   <= '{start: 1'b1, vector: 1'b1};
                                r_state     <= S_VEC1;
                            end
                        end else if (r_active) begin
                            if (idx >= 18'(r_seg_total)) begin
                                // end of arc: emit the exact target
                                r_pos[0]    <= r_target[0];
                                r_pos[1]    <= r_target[1];
                                r_pos[2]    <= r_target[2];
                                r_last      <= 1'b1;
                                r_valid     <= 1'b1;
                                r_active    <= 1'b0;
                                r_seg_index <= idx[16:0];
                            end else begin
                                r_theta     <= n_theta;
                                r_seg_index <= idx[16:0];
                                r_cor_x     <= -hai_pkg::t_vec'(r_off_a);
                                r_cor_y     <= -hai_pkg::t_vec'(r_off_b);
                                r_cor_z     <= hai_pkg::t_ang'($signed(n_theta));
                                r_cor_req   <= '{start: 1'b1, vector: 1'b0};
                                r_state     <= S_ROT;
                            end
                        end
                    end
                end
                S_VEC1: begin
                    if (cor_done) begin
                        r_ang1    <= cor_z[31:0];
                        r_cor_x   <= -hai_pkg::t_vec'(r_off_a);
                        r_cor_y   <= -hai_pkg::t_vec'(r_off_b);
                        r_cor_z   <= '0;
                        r_cor_req <= '{start: 1'b1, vector: 1'b1};
                        r_state   <= S_VEC2;
                    end
                end
                S_VEC2: begin
                    if (cor_done) begin
                        // swept angle, negative turn for clockwise
                        if (r_cw) begin
                            r_sweep <= $signed({2'b00, r_ang1 - cor_z[31:0]} -
                                               hai_pkg::FULL_TURN);
                        end else begin
                            r_sweep <= $signed({2'b00, r_ang1 - cor_z[31:0]});
                        end
                        r_h_a   <= 64'(off_a_abs);
                        r_h_b   <= 64'(off_b_abs);
                        r_h_s   <= '0;
                        r_h_sel <= 1'b0;
                        r_state <= S_HNORM;
                    end
                end
                S_HNORM: begin
                    // bring both legs under 2^31 before squaring
                    if ((r_h_a[63:31] != '0) || (r_h_b[63:31] != '0)) begin
                        r_h_a <= r_h_a >> 1;
                        r_h_b <= r_h_b >> 1;
                        r_h_s <= r_h_s + 6'd1;
                    end else begin
                        r_ari_a   <= r_h_a;
                        r_ari_b   <= r_h_a;
                        r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_MUL};
                        r_state   <= S_HSQA;
                    end
                end
                S_HSQA: begin
                    if (ari_done) begin
                        r_h_sum   <= ari_res;
                        r_ari_a   <= r_h_b;
                        r_ari_b   <= r_h_b;
                        r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_MUL};
                        r_state   <= S_HSQB;
                    end
                end
                S_HSQB: begin
                    if (ari_done) begin
                        r_ari_a   <= r_h_sum + ari_res;
                        r_ari_b   <= '0;
                        r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_SQRT};
                        r_state   <= S_HSQRT;
                    end
                end
                S_HSQRT: begin
                    if (ari_done) begin
                        if (!r_h_sel) begin
                            // radius times swept angle with low 8 bits dropped
                            r_ari_a   <= hyp;
                            r_ari_b   <= 64'(sw_abs[33:8]);
                            r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_MUL};
                            r_state   <= S_MQ;
                        end else begin
                            r_ari_a   <= hyp;
                            r_ari_b   <= seg_div;
                            r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_DIV};
                            r_state   <= S_DIVT;
                        end
                    end
                end
                S_MQ: begin
                    if (ari_done) begin
                        r_ari_a   <= ari_res >> 16;
                        r_ari_b   <= hai_pkg::TWO_PI_Q16;
                        r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_MUL};
                        r_state   <= S_MARC;
                    end
                end
                S_MARC: begin
                    if (ari_done) begin
                        if (tiny) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_h_a   <= arc;
                            r_h_b   <= lin20;
                            r_h_s   <= '0;
                            r_h_sel <= 1'b1;
                            r_state <= S_HNORM;
                        end
                    end
                end
                S_DIVT: begin
                    if (ari_done) begin
                        r_seg_total <= seg_sat;
                        if (seg_sat != '0) begin
                            r_ari_a   <= 64'(sw_abs);
                            r_ari_b   <= 64'(seg_sat);
                            r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_DIV};
                            r_state   <= S_DIVA;
                        end else begin
                            r_angle_step <= '0;
                            r_norm_step  <= '0;
                            r_active     <= 1'b1;
                            r_seg_index  <= '0;
                            r_theta      <= '0;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                S_DIVA: begin
                    if (ari_done) begin
                        r_angle_step <= r_sweep[33] ? -$signed(ari_res[33:0])
                                                    : $signed(ari_res[33:0]);
                        if (r_seg_total > 17'd1) begin
                            r_ari_a   <= 64'(lin_abs);
                            r_ari_b   <= 64'(r_seg_total);
                            r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_DIV};
                            r_state   <= S_DIVN;
                        end else begin
                            r_norm_step <= '0;
                            r_active    <= 1'b1;
                            r_seg_index <= '0;
                            r_theta     <= '0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_DIVN: begin
                    if (ari_done) begin
                        r_norm_step <= r_lin[32] ? (32'd0 - ari_res[31:0]) : ari_res[31:0];
                        r_active    <= 1'b1;
                        r_seg_index <= '0;
                        r_theta     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_ROT: begin
                    if (cor_done) begin
                        // scale out the cordic gain, x first then y
                        r_ya      <= cor_y;
                        r_ari_a   <= 64'(cor_x);
                        r_ari_b   <= hai_pkg::INV_GAIN_Q24;
                        r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_MUL};
                        r_state   <= S_MX;
                    end
                end
                S_MX: begin
                    if (ari_done) begin
                        r_ra      <= rnd[61:30];
                        r_ari_a   <= 64'(r_ya);
                        r_ari_b   <= hai_pkg::INV_GAIN_Q24;
                        r_ari_req <= '{start: 1'b1, op: hai_pkg::OP_MUL};
                        r_state   <= S_MY;
                    end
                end
                S_MY: begin
                    if (ari_done) begin
                        r_norm_pos <= n_norm;
                        unique case (r_plane)
                            PLANE_YZ: begin
                                r_pos[0] <= n_norm; r_pos[1] <= pos_a; r_pos[2] <= pos_b;
                            end
                            PLANE_XZ: begin
                                r_pos[0] <= pos_a; r_pos[1] <= n_norm; r_pos[2] <= pos_b;
                            end
                            default: begin
                                r_pos[0] <= pos_a; r_pos[1] <= pos_b; r_pos[2] <= n_norm;
                            end
                        endcase
                        r_last  <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];

    // --------------------------------------------------------------------
    // checks
    // --------------------------------------------------------------------
    // a result only ever leaves with the sequencer back at rest
    `HAI_ASSERT_IMPLY(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // the target point closes the arc
    `HAI_ASSERT_IMPLY(a_last_ends, i_clk, i_rst_n, o_valid && o_last, !r_active)
    // a step with no arc running yields nothing
    `HAI_ASSERT_NEXT(a_idle_step, i_clk, i_rst_n, start && !busy && i_func && !r_active, !o_valid)
    // a running arc never has passed its segment count
    `HAI_ASSERT_IMPLY(a_index_range, i_clk, i_rst_n, r_active, (r_seg_index < r_seg_total) || (r_seg_index == '0))

endmodule

`default_nettype wire

### dv/helical_arc_interpolator_top_test.sv
// self-checking testbench for the helical arc interpolator top level
// depends on helical_arc_interpolator_top and its sources; holds its own arc predictor
`default_nettype none

module helical_arc_interpolator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STAGES      = 24;
    localparam int  SEG_MAX     = 65536;
    localparam int  SETTLE      = 650;        // longer than the slowest start request
    localparam longint LIMIT    = 4000000;
    localparam logic FN_START   = 1'b0;
    localparam logic FN_STEP    = 1'b1;
    localparam logic [1:0] PL_XY = 2'd0;
    localparam logic [1:0] PL_YZ = 2'd1;
    localparam logic [1:0] PL_XZ = 2'd2;
    localparam logic [1:0] PL_BAD = 2'd3;
    localparam longint TURN_L   = 64'sd4294967296;

    localparam longint ARC_TAN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

    typedef struct {
        logic              func;
        logic [1:0]        plane;
        logic              cw;
        logic signed [31:0] st [3];
        logic signed [31:0] of [3];
        logic signed [31:0] tg [3];
    } t_request;

    typedef struct {
        logic [31:0] p [3];
        logic        last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_request    drv;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        o_valid;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic        o_last;

    // predictor copy of the arc state
    logic        arc_on;
    logic [1:0]  arc_plane;
    logic [31:0] cen_a, cen_b, offs_a, offs_b, norm_pos, norm_step;
    longint      ang_step;
    logic [31:0] seg_total, seg_idx;
    logic [31:0] tgt [3];
    logic [15:0] seg_len;

    t_point      expected_points [$];
    int          errors = 0;
    int          requests = 0;
    int          points_seen = 0;
    int          gap_pct = 0;
    longint      cycles = 0;

    helical_arc_interpolator_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (drv.func),
        .i_plane_select (drv.plane),
        .i_clockwise    (drv.cw),
        .i_start_x      (drv.st[0]),
        .i_start_y      (drv.st[1]),
        .i_start_z      (drv.st[2]),
        .i_off_x        (drv.of[0]),
        .i_off_y        (drv.of[1]),
        .i_off_z        (drv.of[2]),
        .i_target_x     (drv.tg[0]),
        .i_target_y     (drv.tg[1]),
        .i_target_z     (drv.tg[2]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------

    // plane code to (a, b, normal) axis indices; invalid falls back to xy
    function automatic void plane_axes(input logic [1:0] pl, output int ia, output int ib,
                                       output int in_);
        if (pl == PL_YZ) begin
            ia = 1; ib = 2; in_ = 0;
        end else if (pl == PL_XZ) begin
            ia = 0; ib = 2; in_ = 1;
        end else begin
            ia = 0; ib = 1; in_ = 2;
        end
    endfunction

    function automatic longint absl(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned sqrt_floor(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned hypot_floor(input longint unsigned a,
                                                    input longint unsigned b);
        int s;
        s = 0;
        while (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
            a = a >> 1;
            b = b >> 1;
            s++;
        end
        return sqrt_floor(a * a + b * b) << s;
    endfunction

    // cordic vectoring, binary angle of (x, y)
    function automatic logic [31:0] angle_of(input longint x, input longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 32'd0;
        while (absl(x) < 64'sd274877906944 && absl(y) < 64'sd274877906944) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd2147483648;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ARC_TAN[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ARC_TAN[i];
            end
        end
        return z[31:0];
    endfunction

    // cordic rotation with x64 prescale and inverse gain, rounded
    function automatic void turn_vec(input longint x, input longint y, input logic [31:0] ang,
                                     output longint ox, output longint oy);
        longint z, xs, ys;
        z = longint'({32'd0, ang});
        if (z >= 64'sd2147483648) z = z - TURN_L;
        x = x * 64;
        y = y * 64;
        if (z > 64'sd1073741824) begin
            x = -x; y = -y; z = z - 64'sd2147483648;
        end else if (z < -64'sd1073741824) begin
            x = -x; y = -y; z = z + 64'sd2147483648;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ARC_TAN[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ARC_TAN[i];
            end
        end
        ox = (x * 64'sd10188014 + (64'sd1 << 29)) >>> 30;
        oy = (y * 64'sd10188014 + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic void arc_reset();
        arc_on = 1'b0;
        arc_plane = PL_XY;
        cen_a = 0; cen_b = 0; offs_a = 0; offs_b = 0;
        norm_pos = 0; norm_step = 0; ang_step = 0;
        seg_total = 0; seg_idx = 0;
        tgt[0] = 0; tgt[1] = 0; tgt[2] = 0;
        seg_len = 16'd6554;
    endfunction

    // latch a new arc from a start request
    function automatic void arc_setup(input t_request r);
        longint s [3], o [3], t [3];
        longint sweep, lin, segs, r0, r1, rt0, rt1;
        longint unsigned radius, absw, q, arc, lin20, travel, sl;
        logic [31:0] ang;
        int ia, ib, in_;
        arc_on = 1'b0;
        if (r.plane == PL_BAD) return;
        for (int k = 0; k < 3; k++) begin
            s[k] = longint'(r.st[k]);
            o[k] = longint'(r.of[k]);
            t[k] = longint'(r.tg[k]);
        end
        plane_axes(r.plane, ia, ib, in_);
        r0 = -o[ia];
        r1 = -o[ib];
        rt0 = t[ia] - (s[ia] + o[ia]);
        rt1 = t[ib] - (s[ib] + o[ib]);
        ang = angle_of(rt0, rt1) - angle_of(r0, r1);
        sweep = longint'({32'd0, ang});
        if (r.cw) sweep = sweep - TURN_L;
        lin = t[in_] - s[in_];
        radius = hypot_floor(absl(o[ia]), absl(o[ib]));
        absw = absl(sweep);
        q = (radius * (absw >> 8)) >> 16;
        arc = (q * 64'd411775) >> 20;
        lin20 = absl(lin) * 16;
        // travel too short to move: stay idle
        if (arc < 11 && lin20 < 11 && arc * arc + lin20 * lin20 < 110) return;
        travel = hypot_floor(arc, lin20);
        sl = (seg_len == 0) ? 1 : seg_len;
        travel = travel / (sl * 16);
        if (travel > SEG_MAX) travel = SEG_MAX;
        segs = longint'(travel);
        arc_plane = r.plane;
        cen_a = 32'(s[ia] + o[ia]);
        cen_b = 32'(s[ib] + o[ib]);
        offs_a = 32'(o[ia]);
        offs_b = 32'(o[ib]);
        norm_pos = 32'(s[in_]);
        ang_step = (segs > 0) ? sweep / segs : 0;
        norm_step = (segs > 1) ? 32'(lin / segs) : 32'd0;
        seg_total = 32'(segs);
        seg_idx = 0;
        for (int k = 0; k < 3; k++) tgt[k] = 32'(t[k]);
        arc_on = 1'b1;
    endfunction

    // next point of the running arc, if any
    function automatic void arc_advance();
        t_point pt;
        logic [31:0] idx, theta;
        longint ra, rb, prod;
        int ia, ib, in_;
        if (!arc_on) return;
        idx = seg_idx + 1;
        if (idx >= seg_total) begin
            // final point is the stored target exactly
            pt.p[0] = tgt[0]; pt.p[1] = tgt[1]; pt.p[2] = tgt[2];
            pt.last = 1'b1;
            arc_on = 1'b0;
            seg_idx = idx & 32'h1FFFF;
            expected_points.push_back(pt);
            return;
        end
        prod = ang_step * longint'({32'd0, idx});
        theta = prod[31:0];
        turn_vec(-longint'(signed'(offs_a)), -longint'(signed'(offs_b)), theta, ra, rb);
        norm_pos = norm_pos + norm_step;
        plane_axes(arc_plane, ia, ib, in_);
        pt.p[ia] = cen_a + ra[31:0];
        pt.p[ib] = cen_b + rb[31:0];
        pt.p[in_] = norm_pos;
        pt.last = 1'b0;
        seg_idx = idx;
        expected_points.push_back(pt);
    endfunction

    // ---------------- monitor and checker ----------------

    always @(posedge i_clk) begin
        t_point ex;
        logic [31:0] got [3];
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t timeout with %0d points outstanding", $time, expected_points.size());
            $display("CHECK FAILED");
            $finish;
        end
        if (!i_rst_n) begin
            arc_reset();
        end else begin
            if (o_valid) begin
                points_seen++;
                got[0] = o_pos_x; got[1] = o_pos_y; got[2] = o_pos_z;
                if (expected_points.size() == 0) begin
                    $display("%0t unexpected point x=%h y=%h z=%h last=%b", $time,
                             got[0], got[1], got[2], o_last);
                    errors++;
                end else begin
                    ex = expected_points.pop_front();
                    for (int k = 0; k < 3; k++)
                        if (got[k] !== ex.p[k]) begin
                            $display("%0t pos[%0d] mismatch: expected %h actual %h", $time, k,
                                     ex.p[k], got[k]);
                            errors++;
                        end
                    if (o_last !== ex.last) begin
                        $display("%0t last mismatch: expected %b actual %b", $time,
                                 ex.last, o_last);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                requests++;
                if (drv.func == FN_START) arc_setup(drv);
                else arc_advance();
            end
            if (i_cfg_we) seg_len = i_cfg_wdata;
        end
    end

    // ---------------- driving ----------------

    // drives one request at a falling edge and returns once it is taken
    task automatic send_request(input t_request r);
        @(negedge i_clk);
        while (busy || ($urandom_range(99) < gap_pct)) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        drv = r;
        start = 1'b1;
        @(posedge i_clk);
        #1;
    endtask

    task automatic wait_drained();
        while (expected_points.size() != 0) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // segment length changes only with nothing in flight
    task automatic write_seg_len(input logic [15:0] v);
        wait_drained();
        repeat (SETTLE) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_wdata = 16'($urandom);
    endtask

    function automatic t_request noise_request(input logic fn);
        t_request r;
        r.func = fn;
        r.plane = 2'($urandom);
        r.cw = 1'($urandom);
        for (int k = 0; k < 3; k++) begin
            r.st[k] = $urandom; r.of[k] = $urandom; r.tg[k] = $urandom;
        end
        return r;
    endfunction

    function automatic int signed spread(input int unsigned range);
        return int'($urandom_range(2 * range)) - int'(range);
    endfunction

    // well-formed arc of a few segments at the current length, plus up to cap steps
    task automatic run_arc(input int cap, input logic [1:0] pl);
        t_request r;
        int ia, ib, in_, rng, n;
        r = noise_request(FN_START);
        r.plane = pl;
        plane_axes(pl, ia, ib, in_);
        rng = (seg_len == 0 ? 1 : seg_len) * 4 + 4;
        r.of[ia] = spread(rng);
        r.of[ib] = spread(rng);
        r.tg[ia] = r.st[ia] + r.of[ia] + spread(rng);
        r.tg[ib] = r.st[ib] + r.of[ib] + spread(rng);
        r.tg[in_] = r.st[in_] + spread(rng * 2);
        send_request(r);
        n = 0;
        while (arc_on && n < cap) begin
            send_request(noise_request(FN_STEP));
            n++;
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        t_request r;
        // step with no arc running
        send_request(noise_request(FN_STEP));
        // invalid plane with start and offset fields at their extremes, targets all ones
        r = noise_request(FN_START);
        r.plane = PL_BAD;
        for (int k = 0; k < 3; k++) begin
            r.st[k] = 32'h7FFF_FFFF; r.of[k] = 32'h8000_0000; r.tg[k] = 32'hFFFF_FFFF;
        end
        send_request(r);
        send_request(noise_request(FN_STEP));
        // no travel at all: target equals start, zero offset
        r.plane = PL_XY;
        for (int k = 0; k < 3; k++) begin
            r.st[k] = 32'h8000_0000; r.of[k] = 0; r.tg[k] = 32'h8000_0000;
        end
        send_request(r);
        send_request(noise_request(FN_STEP));
        // full-range arc, saturated count; a few points then a cancelling start
        r = noise_request(FN_START);
        r.plane = PL_XZ;
        r.of[0] = 32'h7FFF_FFFF; r.of[2] = 32'h8000_0000;
        send_request(r);
        repeat (3) send_request(noise_request(FN_STEP));
        // each plane once in a random direction, run to the target
        run_arc(300, PL_XY);
        run_arc(300, PL_YZ);
        run_arc(300, PL_XZ);
    endtask

    task automatic test_config_extremes();
        logic [15:0] lens [5] = '{16'd1, 16'd65535, 16'd0, 16'd6554, 16'd200};
        foreach (lens[i]) begin
            write_seg_len(lens[i]);
            run_arc(300, PL_XY);
            run_arc(300, PL_YZ);
            // the xz arc may be shorter than a segment, which gives zero segments: target only
            run_arc(300, PL_XZ);
        end
    endtask

    task automatic test_drain_pause();
        run_arc(0, 2'($urandom_range(2)));
        while (arc_on) begin
            wait_drained();
            send_request(noise_request(FN_STEP));
        end
    endtask

    task automatic test_random_arcs(input int pct, input int quota);
        int goal, dice;
        gap_pct = pct;
        write_seg_len(16'($urandom_range(1, 65535)));
        goal = requests + quota;
        while (requests < goal) begin
            dice = $urandom_range(99);
            if (dice < 75) begin
                run_arc(($urandom_range(9) == 0) ? $urandom_range(3) : 300,
                        2'($urandom_range(2)));
            end else if (dice < 92) begin
                send_request(noise_request(FN_START));
                repeat ($urandom_range(3)) send_request(noise_request(FN_STEP));
            end else begin
                send_request(noise_request(FN_STEP));
            end
        end
    endtask

    initial begin
        drv = noise_request(FN_STEP);
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_cases();
        test_config_extremes();
        test_drain_pause();
        test_random_arcs(0, 230);
        test_random_arcs(54, 230);
        test_random_arcs(12, 230);
        test_random_arcs(0, 230);
        gap_pct = 0;
        wait_drained();
        repeat (SETTLE) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        $display("covered %0d requests and %0d points over three planes, both directions,",
                 requests, points_seen);
        $display("segment lengths from zero to full scale and sender gaps of 0, 12 and 54 pct");
        if (errors == 0 && expected_points.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d points never arrived", errors,
                     expected_points.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/hai_pkg.sv
sv/hai_arith.sv
sv/hai_cordic.sv
sv/helical_arc_interpolator_top.sv
dv/helical_arc_interpolator_top_test.sv
